>>> sv/iira_pkg.sv
`default_nettype none

package iira_pkg;

    // Storage geometry.
    localparam int DEPTH  = 64;
    localparam int ELEM_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths of the command and result words.
    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_WRITE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value_in;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic [CNT_W-1:0]   count_out;
        logic [STAT_W-1:0]  status;
    } t_out_word;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic              insert;
        logic              remove;
        logic              write;
        logic [IDX_W-1:0]  pos;
        logic [ELEM_W-1:0] value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> sv/iira_cell.sv
`default_nettype none

module iira_cell (
    input  wire logic                        i_clk,
    input  wire logic [iira_pkg::IDX_W-1:0]  i_index,
    input  wire iira_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [iira_pkg::ELEM_W-1:0] i_prev,
    input  wire logic [iira_pkg::ELEM_W-1:0] i_next,
    output logic      [iira_pkg::ELEM_W-1:0] o_data,
    output logic      [iira_pkg::ELEM_W-1:0] o_hit_data
);

    logic [iira_pkg::ELEM_W-1:0] r_data;
    logic [iira_pkg::ELEM_W-1:0] n_data;
    logic                        above;
    logic                        at_pos;

    assign above  = i_index > i_ctrl.pos;
    assign at_pos = i_index == i_ctrl.pos;

    // An insert pulls the lower neighbor in, a remove pulls the upper one.
    always_comb begin
        n_data = r_data;
        if (i_ctrl.insert) begin
            if (above) begin
                n_data = i_prev;
            end else if (at_pos) begin
                n_data = i_ctrl.value;
            end
        end else if (i_ctrl.remove) begin
            if (above || at_pos) begin
                n_data = i_next;
            end
        end else if (i_ctrl.write && at_pos) begin
            n_data = i_ctrl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // The addressed cell offers its old word for the result.
    assign o_data     = r_data;
    assign o_hit_data = at_pos ? r_data : '0;

endmodule

`default_nettype wire

>>> sv/indexed_insert_remove_array_top.sv
// Channel  | Ports                      | Handshake
// ---------+----------------------------+---------------------------------------
// command  | i_word (cmd, position,     | taken at a clock edge with start high
//          |   value_in)                |   and busy low
// result   | o_word (value_out,         | o_strobe high for one cycle, no stall
//          |   count_out, status)       |
//
// The edge that takes a command checks the index and latches the decode into
// the command registers; after them the row of cells shifts and the result
// register captures the result, which shows on o_word with o_strobe.
// busy is high while the row shifts, so no new command is taken until the
// result is registered. Reset (synchronous, active low) clears the count and
// the control; cell contents are left as they are. The receiver cannot stall.
`default_nettype none

module indexed_insert_remove_array_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire iira_pkg::t_in_word i_word,
    output iira_pkg::t_out_word     o_word,
    output logic                    o_strobe
);

    localparam logic [iira_pkg::CNT_W-1:0] FULL_COUNT = iira_pkg::CNT_W'(iira_pkg::DEPTH);

    logic                        accept;
    logic                        pos_bad;
    logic                        is_insert;
    logic [iira_pkg::POS_W-1:0]  cnt_ext;

    logic                        r_pend;
    logic                        r_read;
    logic [iira_pkg::STAT_W-1:0] r_status;
    logic [iira_pkg::CNT_W-1:0]  r_count;
    logic [iira_pkg::CNT_W-1:0]  n_count;
    iira_pkg::t_cell_ctrl        r_ctrl;
    iira_pkg::t_cell_ctrl        n_ctrl;
    logic [iira_pkg::STAT_W-1:0] n_status;
    logic                        r_strobe;
    iira_pkg::t_out_word         r_out;

    logic [iira_pkg::ELEM_W-1:0] cell_data [iira_pkg::DEPTH];
    logic [iira_pkg::ELEM_W-1:0] hit_data  [iira_pkg::DEPTH];
    logic [iira_pkg::DEPTH-1:0]  hit_col   [iira_pkg::ELEM_W];
    logic [iira_pkg::ELEM_W-1:0] read_word;

    assign accept    = start && !r_pend;
    assign busy      = r_pend;
    assign is_insert = i_word.cmd == iira_pkg::CMD_INSERT;
    assign cnt_ext   = iira_pkg::POS_W'(r_count);
    assign pos_bad   = is_insert ? (i_word.position > cnt_ext)
                                 : (i_word.position >= cnt_ext);

    // Check the command word and decode it into the row control.
    always_comb begin
        n_ctrl       = '0;
        n_ctrl.pos   = i_word.position[iira_pkg::IDX_W-1:0];
        n_ctrl.value = i_word.value_in[iira_pkg::ELEM_W-1:0];
        n_status     = iira_pkg::ST_OK;
        n_count      = r_count;
        if (pos_bad) begin
            n_status = iira_pkg::ST_RANGE;
        end else if (is_insert && r_count == FULL_COUNT) begin
            n_status = iira_pkg::ST_FULL;
        end else begin
            case (iira_pkg::t_cmd'(i_word.cmd))
                iira_pkg::CMD_INSERT: begin
                    n_ctrl.insert = 1'b1;
                    n_count       = r_count + 1'b1;
                end
                iira_pkg::CMD_REMOVE: begin
                    n_ctrl.remove = 1'b1;
                    n_count       = r_count - 1'b1;
                end
                iira_pkg::CMD_WRITE: begin
                    n_ctrl.write = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Command stage: control and payload registers; the payload is not reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend        <= 1'b0;
            r_read        <= 1'b0;
            r_count       <= '0;
            r_ctrl.insert <= 1'b0;
            r_ctrl.remove <= 1'b0;
            r_ctrl.write  <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_pend   <= accept;
            r_strobe <= r_pend;
            if (accept) begin
                r_read        <= !is_insert && n_status == iira_pkg::ST_OK;
                r_count       <= n_count;
                r_ctrl.insert <= n_ctrl.insert;
                r_ctrl.remove <= n_ctrl.remove;
                r_ctrl.write  <= n_ctrl.write;
                r_status      <= n_status;
                r_ctrl.pos    <= n_ctrl.pos;
                r_ctrl.value  <= n_ctrl.value;
            end else begin
                r_ctrl.insert <= 1'b0;
                r_ctrl.remove <= 1'b0;
                r_ctrl.write  <= 1'b0;
            end
        end
    end

    // The row of cells; the ends see zero beyond them.
    for (genvar g = 0; g < iira_pkg::DEPTH; g++) begin : g_cell
        logic [iira_pkg::ELEM_W-1:0] prev_w;
        logic [iira_pkg::ELEM_W-1:0] next_w;

        if (g == 0) begin : g_lo
            assign prev_w = '0;
        end else begin : g_lo
            assign prev_w = cell_data[g-1];
        end
        if (g == iira_pkg::DEPTH - 1) begin : g_hi
            assign next_w = '0;
        end else begin : g_hi
            assign next_w = cell_data[g+1];
        end

        iira_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (iira_pkg::IDX_W'(g)),
            .i_ctrl     (r_ctrl),
            .i_prev     (prev_w),
            .i_next     (next_w),
            .o_data     (cell_data[g]),
            .o_hit_data (hit_data[g])
        );
    end

    // Only the addressed cell drives a nonzero word, so an OR gathers it.
    for (genvar b = 0; b < iira_pkg::ELEM_W; b++) begin : g_bit
        for (genvar c = 0; c < iira_pkg::DEPTH; c++) begin : g_col
            assign hit_col[b][c] = hit_data[c][b];
        end
        assign read_word[b] = |hit_col[b];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out.value_out <= r_read ? iira_pkg::VALUE_W'(read_word) : '0;
            r_out.count_out <= r_count;
            r_out.status    <= r_status;
        end
    end

    assign o_word   = r_out;
    assign o_strobe = r_strobe;

`ifndef SYNTHESIS
    // A taken command is always followed by its result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("result strobe missing after a command");

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("element count beyond capacity");

    // A full status is only reported with a full list.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.status == iira_pkg::ST_FULL) |-> o_word.count_out == FULL_COUNT)
        else $error("full status with room left");

    // Error results return a zero word.
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.status != iira_pkg::ST_OK) |-> o_word.value_out == '0)
        else $error("nonzero word on an error result");
`endif

endmodule

`default_nettype wire
